// ===== design/ascm_pkg.sv =====
// shared constants and register codes for the audio safety ceiling/mute block
`timescale 1ns / 1ps
package ascm_pkg;

  // default sample width, Q1.(SAMPLE_BITS-1)
  localparam int SAMPLE_BITS_DEF = 24;

  // frame counter and watchdog width
  localparam int COUNT_BITS = 32;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CEILING   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WATCHDOG  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_STEP = 2'd2;

  // register reset values
  localparam logic [COUNT_BITS-1:0] WATCHDOG_RST  = 32'd5760000;
  localparam int                    FADE_STEP_RST = 874;

endpackage

// ===== design/ascm_in_if.sv =====
// input sample channel: valid/ready plus sample payload
`timescale 1ns / 1ps
interface ascm_in_if #(
  parameter int SAMPLE_BITS = ascm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          non_finite;
  logic                          frame_end;
  logic                          block_end;

  modport source (output valid, sample, non_finite, frame_end, block_end, input ready);
  modport sink   (input valid, sample, non_finite, frame_end, block_end, output ready);
endinterface

// ===== design/ascm_out_if.sv =====
// result channel: valid/ready plus output sample, mute state and peaks
`timescale 1ns / 1ps
interface ascm_out_if #(
  parameter int SAMPLE_BITS = ascm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          muted;
  logic        [SAMPLE_BITS-1:0] in_peak;
  logic        [SAMPLE_BITS-2:0] peak_out;

  modport source (output valid, out_sample, muted, in_peak, peak_out, input ready);
  modport sink   (input valid, out_sample, muted, in_peak, peak_out, output ready);
endinterface

// ===== design/ascm_cfg_if.sv =====
// configuration write channel: valid/ready plus register index and data
`timescale 1ns / 1ps
interface ascm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ascm_pkg::CFG_IDX_BITS-1:0]  index;
  logic [ascm_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/audio_safety_ceiling_mute_top.sv =====
// top level of the audio output safety stage: clamp, fade-in and latched mute
//
// Channels: in_ch takes one channel sample per beat with its non-finite,
// frame-end and block-end flags; out_ch returns one result beat per input
// beat with the clamped and faded sample, the mute state and the running
// input and output peaks. cfg writes the ceiling (index 0), the watchdog
// frame count (index 1) and the fade step (index 2); writes are always taken
// and should only be issued while no sample is in flight.
// Path: an accepted input beat passes the input register, then the result
// register after the clamp and multiply, before it is offered on out_ch.
// Throughput: one beat per cycle while out_ch is ready, set by the single gain
// multiply between the two registers, where block state updates once per beat.
// Reset: registers return to their defaults (ceiling 0.5, 120 s watchdog,
// 0.2 s fade), fade gain, frame count and peaks clear, mute releases.
// Stall: when out_ch is not ready the result holds, the input register keeps
// one more beat, and in_ch.ready drops only once both are full.
`timescale 1ns / 1ps
module audio_safety_ceiling_mute_top #(
  parameter int SAMPLE_BITS = ascm_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ascm_in_if.sink     in_ch,
  ascm_out_if.source  out_ch,
  ascm_cfg_if.sink    cfg
);
  import ascm_pkg::*;

  logic [SAMPLE_BITS-2:0]        ceiling;
  logic [COUNT_BITS-1:0]         watchdog_frames;
  logic [SAMPLE_BITS-1:0]        fade_step;
  logic                          advance;
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_non_finite;
  logic                          s1_frame_end;
  logic                          s1_block_end;

  // configuration registers
  ascm_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .ceiling         (ceiling),
    .watchdog_frames (watchdog_frames),
    .fade_step       (fade_step)
  );

  // input register
  ascm_in_reg #(.SAMPLE_BITS(SAMPLE_BITS)) u_in (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .advance       (advance),
    .s1_valid      (s1_valid),
    .s1_sample     (s1_sample),
    .s1_non_finite (s1_non_finite),
    .s1_frame_end  (s1_frame_end),
    .s1_block_end  (s1_block_end)
  );

  // processing and result register
  ascm_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .clk             (clk),
    .rst             (rst),
    .ceiling         (ceiling),
    .watchdog_frames (watchdog_frames),
    .fade_step       (fade_step),
    .s1_valid        (s1_valid),
    .s1_sample       (s1_sample),
    .s1_non_finite   (s1_non_finite),
    .s1_frame_end    (s1_frame_end),
    .s1_block_end    (s1_block_end),
    .advance         (advance),
    .out_ch          (out_ch)
  );

endmodule

// ===== design/ascm_cfg_regs.sv =====
// configuration registers: ceiling, watchdog frame count, fade step
`timescale 1ns / 1ps
module ascm_cfg_regs #(
  parameter int SAMPLE_BITS = ascm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  ascm_cfg_if.sink                          cfg,
  output logic [SAMPLE_BITS-2:0]            ceiling,
  output logic [ascm_pkg::COUNT_BITS-1:0]   watchdog_frames,
  output logic [SAMPLE_BITS-1:0]            fade_step
);
  import ascm_pkg::*;

  localparam int FRAC_BITS = SAMPLE_BITS - 1;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register write decode, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling         <= FRAC_BITS'(1) << (FRAC_BITS - 1);
      watchdog_frames <= WATCHDOG_RST;
      fade_step       <= SAMPLE_BITS'(FADE_STEP_RST);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_CEILING:   ceiling         <= cfg.data[FRAC_BITS-1:0];
        CFG_WATCHDOG:  watchdog_frames <= cfg.data[COUNT_BITS-1:0];
        CFG_FADE_STEP: fade_step       <= cfg.data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ascm_in_reg.sv =====
// input register stage holding one sample beat
`timescale 1ns / 1ps
module ascm_in_reg #(
  parameter int SAMPLE_BITS = ascm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  ascm_in_if.sink                       in_ch,
  input  logic                          advance,
  output logic                          s1_valid,
  output logic signed [SAMPLE_BITS-1:0] s1_sample,
  output logic                          s1_non_finite,
  output logic                          s1_frame_end,
  output logic                          s1_block_end
);
  logic load;

  // take a beat when the stage is empty or moving on
  assign in_ch.ready = !s1_valid || advance;
  assign load        = in_ch.valid && in_ch.ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      s1_sample     <= in_ch.sample;
      s1_non_finite <= in_ch.non_finite;
      s1_frame_end  <= in_ch.frame_end;
      s1_block_end  <= in_ch.block_end;
    end
  end

endmodule

// ===== design/ascm_core.sv =====
// clamp, fade multiply, mute latch, peak tracking and result register
`timescale 1ns / 1ps
module ascm_core #(
  parameter int SAMPLE_BITS = ascm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [SAMPLE_BITS-2:0]          ceiling,
  input  logic [ascm_pkg::COUNT_BITS-1:0] watchdog_frames,
  input  logic [SAMPLE_BITS-1:0]          fade_step,
  input  logic                            s1_valid,
  input  logic signed [SAMPLE_BITS-1:0]   s1_sample,
  input  logic                            s1_non_finite,
  input  logic                            s1_frame_end,
  input  logic                            s1_block_end,
  output logic                            advance,
  ascm_out_if.source                      out_ch
);
  import ascm_pkg::*;

  localparam int W = SAMPLE_BITS;
  localparam int F = SAMPLE_BITS - 1;
  localparam logic [W:0] UNITY = {2'b01, {F{1'b0}}};

  logic [COUNT_BITS-1:0] frame_count;
  logic [W-1:0]          fade_gain;
  logic                  mute_latch;
  logic [W-1:0]          input_peak;
  logic [F-1:0]          output_peak;

  logic                  take;
  logic                  neg;
  logic [W-1:0]          in_mag;
  logic [F-1:0]          clamped;
  logic [W+F-1:0]        product;
  logic [W+F-1:0]        rounded;
  logic                  mute_pre;
  logic                  active;
  logic [F-1:0]          out_mag;
  logic [W-1:0]          result;
  logic [W-1:0]          in_peak_next;
  logic [F-1:0]          output_peak_next;
  logic [W:0]            gain_sum;
  logic [W-1:0]          fade_gain_next;

  // stage moves when the result register is free
  assign advance = !out_ch.valid || out_ch.ready;
  assign take    = s1_valid && advance;

  // magnitude and clamp
  assign neg     = s1_sample[W-1];
  assign in_mag  = neg ? (~s1_sample + W'(1)) : s1_sample;
  assign clamped = (in_mag > {1'b0, ceiling}) ? ceiling : in_mag[F-1:0];

  // fade gain multiply, round half away from zero on the magnitude
  assign product = clamped * fade_gain;
  assign rounded = product + ((W + F)'(1) << (F - 1));

  // watchdog check uses the count before this beat's frame end
  assign mute_pre = mute_latch || (frame_count >= watchdog_frames);
  assign active   = !mute_pre && !s1_non_finite;
  assign out_mag  = active ? rounded[2*F-1:F] : '0;
  assign result   = neg ? (~{1'b0, out_mag} + W'(1)) : {1'b0, out_mag};

  // running peaks including this sample
  assign in_peak_next     = (!s1_non_finite && in_mag > input_peak) ? in_mag : input_peak;
  assign output_peak_next = (out_mag > output_peak) ? out_mag : output_peak;

  // saturating fade gain step
  assign gain_sum       = {1'b0, fade_gain} + {1'b0, fade_step};
  assign fade_gain_next = (gain_sum > UNITY) ? UNITY[W-1:0] : gain_sum[W-1:0];

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      fade_gain   <= '0;
      mute_latch  <= 1'b0;
      input_peak  <= '0;
      output_peak <= '0;
    end else if (take) begin
      mute_latch <= mute_pre || s1_non_finite;
      if (s1_frame_end) begin
        fade_gain <= fade_gain_next;
        if (frame_count != '1) begin
          frame_count <= frame_count + COUNT_BITS'(1);
        end
      end
      if (s1_block_end) begin
        input_peak  <= '0;
        output_peak <= '0;
      end else begin
        input_peak  <= in_peak_next;
        output_peak <= output_peak_next;
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= s1_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.out_sample <= result;
      out_ch.muted      <= mute_pre || s1_non_finite;
      out_ch.in_peak    <= in_peak_next;
      out_ch.peak_out   <= output_peak_next;
    end
  end

endmodule

// ===== test/audio_safety_ceiling_mute_top_test.sv =====
// testbench for the audio safety stage: clamp, fade-in, latched mute and peak tracking
`timescale 1ns / 1ps
module audio_safety_ceiling_mute_top_test;
  import ascm_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic [SB:0] UNITY = (SB + 1)'(1) << (SB - 1);
  localparam logic [2*SB:0] ROUND_HALF = (2 * SB + 1)'(1) << (SB - 2);
  localparam logic [CFG_DATA_BITS-1:0] HALF_GAIN = 32'd4194304;
  localparam logic signed [SB-1:0] FULL_POS = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] FULL_NEG = {1'b1, {(SB-1){1'b0}}};

  typedef struct packed {
    logic signed [SB-1:0] sample;
    logic                 non_finite;
    logic                 frame_end;
    logic                 block_end;
  } audio_item_t;

  typedef struct packed {
    logic signed [SB-1:0] out_sample;
    logic                 muted;
    logic [SB-1:0]        in_peak;
    logic [SB-2:0]        peak_out;
  } safety_result_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_t;

  logic clk;
  logic rst;

  ascm_in_if  #(.SAMPLE_BITS(SB)) in_ch();
  ascm_out_if #(.SAMPLE_BITS(SB)) out_ch();
  ascm_cfg_if                     cfg();

  audio_safety_ceiling_mute_top #(.SAMPLE_BITS(SB)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // shadow registers and block state
  logic [SB-2:0]     ceil_m;
  logic [31:0]       wdog_m;
  logic [SB-1:0]     step_m;
  logic [31:0]       frame_cnt_m;
  logic [SB-1:0]     gain_m;
  logic              mute_m;
  logic [SB-1:0]     in_peak_m;
  logic [SB-2:0]     peak_out_m;

  audio_item_t    sample_beats_q[$];
  safety_result_t safe_out_q[$];
  audio_item_t    driven_item;
  int             mismatch_count;
  int             gap_left;
  int             burst_left;
  int             stall_left;
  stall_mode_t    stall_mode;

  // register write as the block applies it
  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_CEILING:   ceil_m = data[SB-2:0];
      CFG_WATCHDOG:  wdog_m = data;
      CFG_FADE_STEP: step_m = data[SB-1:0];
      default: ;
    endcase
  endfunction

  // expected result of one sample beat, advancing the shadow state
  function automatic safety_result_t clamp_fade_mute(input audio_item_t it);
    safety_result_t r;
    logic [SB-1:0]  in_mag;
    logic [SB-1:0]  clamped;
    logic [2*SB:0]  prod;
    logic [SB-2:0]  out_mag;
    logic [SB-1:0]  mag_w;
    logic [SB:0]    gain_sum;
    in_mag = it.sample[SB-1] ? (~it.sample + 1'b1) : it.sample;
    out_mag = '0;
    r.out_sample = '0;
    // watchdog looks at the count before this beat's frame end
    if (!mute_m && frame_cnt_m >= wdog_m)
      mute_m = 1'b1;
    if (!it.non_finite && in_mag > in_peak_m)
      in_peak_m = in_mag;
    if (!mute_m) begin
      if (it.non_finite) begin
        mute_m = 1'b1;
      end else begin
        clamped = (in_mag > {1'b0, ceil_m}) ? {1'b0, ceil_m} : in_mag;
        prod = clamped * gain_m + ROUND_HALF;
        out_mag = prod[SB-1 +: SB-1];
        mag_w = {1'b0, out_mag};
        r.out_sample = it.sample[SB-1] ? (~mag_w + 1'b1) : mag_w;
      end
    end
    if (out_mag > peak_out_m)
      peak_out_m = out_mag;
    r.muted = mute_m;
    r.in_peak = in_peak_m;
    r.peak_out = peak_out_m;
    // fade and frame count advance after the sample
    if (it.frame_end) begin
      gain_sum = gain_m + step_m;
      gain_m = (gain_sum > UNITY) ? UNITY[SB-1:0] : gain_sum[SB-1:0];
      if (frame_cnt_m != '1)
        frame_cnt_m = frame_cnt_m + 1;
    end
    if (it.block_end) begin
      in_peak_m = '0;
      peak_out_m = '0;
    end
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sample driver: bursts of beats with random gaps
  always @(posedge clk) begin : drive_samples
    logic nv;
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 8;
    end else begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        safe_out_q.push_back(clamp_fade_mute(driven_item));
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (sample_beats_q.size() > 0) begin
          driven_item = sample_beats_q.pop_front();
          nv = 1'b1;
          in_ch.sample <= driven_item.sample;
          in_ch.non_finite <= driven_item.non_finite;
          in_ch.frame_end <= driven_item.frame_end;
          in_ch.block_end <= driven_item.block_end;
          if (burst_left > 1) begin
            burst_left = burst_left - 1;
          end else begin
            gap_left = $urandom_range(0, 7);
            // now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
          end
        end
      end
      in_ch.valid <= nv;
    end
  end

  // result receiver: ready follows a stall pattern that changes over time
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      stall_mode <= STALL_NONE;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left = stall_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_ch.ready <= 1'b1;
        STALL_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
        STALL_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     out_ch.ready <= (stall_left % 20 == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    safety_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (safe_out_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, expected none, got out_sample %0d",
                 $time, out_ch.out_sample);
      end else begin
        exp_r = safe_out_q.pop_front();
        if (out_ch.out_sample !== exp_r.out_sample) begin
          mismatch_count++;
          $display("%0t: out_sample expected %0d got %0d",
                   $time, exp_r.out_sample, out_ch.out_sample);
        end
        if (out_ch.muted !== exp_r.muted) begin
          mismatch_count++;
          $display("%0t: muted expected %0d got %0d", $time, exp_r.muted, out_ch.muted);
        end
        if (out_ch.in_peak !== exp_r.in_peak) begin
          mismatch_count++;
          $display("%0t: in_peak expected %0d got %0d", $time, exp_r.in_peak, out_ch.in_peak);
        end
        if (out_ch.peak_out !== exp_r.peak_out) begin
          mismatch_count++;
          $display("%0t: peak_out expected %0d got %0d",
                   $time, exp_r.peak_out, out_ch.peak_out);
        end
      end
    end
  end

  // wait until every queued beat is sent and every result is back
  task automatic wait_drain();
    do @(negedge clk);
    while (sample_beats_q.size() != 0 || in_ch.valid || safe_out_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk);
    while (!cfg.ready);
    apply_reg(idx, data);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_sample(input logic signed [SB-1:0] s, input logic nf,
                             input logic fe, input logic be);
    audio_item_t it;
    it.sample = s;
    it.non_finite = nf;
    it.frame_end = fe;
    it.block_end = be;
    sample_beats_q.push_back(it);
  endtask

  // random level: full range, quiet, near the ceiling, or full scale, unit or zero
  function automatic logic signed [SB-1:0] random_level();
    logic [31:0]          r;
    logic signed [SB-1:0] s;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: s = r[SB-1:0];
      1: s = $signed({{(SB-8){r[8]}}, r[7:0]});
      2: begin
        s = SB'($signed({1'b0, ceil_m}) + $signed(SB'($urandom_range(0, 6))) - 3);
        if (r[31])
          s = -s;
      end
      default: begin
        case (r[1:0])
          2'd0: s = FULL_POS;
          2'd1: s = FULL_NEG;
          2'd2: s = r[2] ? SB'(1) : SB'(-1);
          default: s = '0;
        endcase
      end
    endcase
    return s;
  endfunction

  // well-formed frames of 1..4 channels with occasional stray flags
  task automatic queue_frames(input int n, input int nf_pct);
    int chans;
    int ch;
    logic fe;
    logic be;
    chans = $urandom_range(1, 4);
    ch = 0;
    for (int k = 0; k < n; k++) begin
      fe = (ch == chans - 1);
      be = fe && ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 19) == 0)
        fe = ~fe;
      if ($urandom_range(0, 29) == 0)
        be = 1'b1;
      push_sample(random_level(), ($urandom_range(0, 99) < nf_pct), fe, be);
      if (ch == chans - 1) begin
        ch = 0;
        if ($urandom_range(0, 9) == 0)
          chans = $urandom_range(1, 4);
      end else begin
        ch++;
      end
    end
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.non_finite = 1'b0;
    in_ch.frame_end = 1'b0;
    in_ch.block_end = 1'b0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_CEILING;
    cfg.data = '0;
    mismatch_count = 0;
    ceil_m = (SB - 1)'(1) << (SB - 2);
    wdog_m = WATCHDOG_RST;
    step_m = SB'(FADE_STEP_RST);
    frame_cnt_m = '0;
    gain_m = '0;
    mute_m = 1'b0;
    in_peak_m = '0;
    peak_out_m = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: zero gain, then small fade steps, half-scale ceiling
    push_sample(FULL_POS, 1'b0, 1'b0, 1'b0);
    push_sample(FULL_NEG, 1'b0, 1'b1, 1'b0);
    push_sample(FULL_NEG, 1'b0, 1'b1, 1'b0);
    push_sample('0, 1'b0, 1'b0, 1'b1);
    push_sample(SB'(1), 1'b0, 1'b0, 1'b0);
    push_sample(SB'(-1), 1'b0, 1'b0, 1'b0);
    push_sample(24'sd4194305, 1'b0, 1'b0, 1'b0);
    push_sample(24'sd4194304, 1'b0, 1'b0, 1'b1);
    wait_drain();

    // bring the gain to exactly one half to hit rounding ties
    write_reg(CFG_CEILING, 32'hFFFF_FFFF);
    write_reg(CFG_WATCHDOG, 32'hFFFF_FFFF);
    write_reg(CFG_FADE_STEP, HALF_GAIN - gain_m);
    push_sample(24'sd12345, 1'b0, 1'b1, 1'b0);
    push_sample(SB'(3), 1'b0, 1'b0, 1'b0);
    push_sample(SB'(-3), 1'b0, 1'b0, 1'b0);
    push_sample(SB'(1), 1'b0, 1'b0, 1'b0);
    push_sample(SB'(-1), 1'b0, 1'b0, 1'b0);
    push_sample(FULL_POS, 1'b0, 1'b0, 1'b0);
    push_sample(FULL_NEG, 1'b0, 1'b0, 1'b0);
    push_sample(FULL_POS - SB'(1), 1'b0, 1'b0, 1'b0);
    push_sample(FULL_NEG + SB'(1), 1'b0, 1'b0, 1'b1);
    wait_drain();

    // gain held at one half, random ceiling
    write_reg(CFG_FADE_STEP, '0);
    write_reg(CFG_CEILING, $urandom);
    queue_frames(200, 0);
    wait_drain();

    // slow fade-in; stray write to the unused index
    write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_CEILING, $urandom);
    write_reg(CFG_FADE_STEP, $urandom_range(1, 20000));
    queue_frames(250, 0);
    wait_drain();

    // zero ceiling silences everything
    write_reg(CFG_CEILING, '0);
    write_reg(CFG_FADE_STEP, $urandom_range(1, 20000));
    queue_frames(60, 0);
    wait_drain();

    write_reg(CFG_CEILING, $urandom);
    write_reg(CFG_FADE_STEP, $urandom_range(1, 40000));
    queue_frames(250, 0);
    wait_drain();

    // oversized step: gain saturates at unity, full-scale ceiling
    write_reg(CFG_CEILING, CFG_DATA_BITS'({1'b0, {(SB-1){1'b1}}}));
    write_reg(CFG_FADE_STEP, 32'hFF80_0000);
    push_sample('0, 1'b0, 1'b1, 1'b0);
    push_sample(FULL_POS, 1'b0, 1'b0, 1'b0);
    push_sample(FULL_NEG, 1'b0, 1'b0, 1'b0);
    push_sample(SB'(1), 1'b0, 1'b0, 1'b0);
    push_sample(SB'(-1), 1'b0, 1'b1, 1'b1);
    queue_frames(150, 0);
    wait_drain();

    write_reg(CFG_CEILING, $urandom);
    write_reg(CFG_FADE_STEP, $urandom);
    queue_frames(100, 0);
    wait_drain();

    // final phase: the mute latches for good, by watchdog or non-finite sample
    case ($urandom_range(0, 2))
      0: begin
        write_reg(CFG_WATCHDOG, frame_cnt_m + $urandom_range(1, 4));
        queue_frames(30, 0);
        queue_frames(120, 15);
      end
      1: begin
        queue_frames(10, 0);
        queue_frames(140, 12);
      end
      default: begin
        write_reg(CFG_WATCHDOG, '0);
        queue_frames(150, 15);
      end
    endcase
    wait_drain();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && safe_out_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
design/ascm_pkg.sv
design/ascm_in_if.sv
design/ascm_out_if.sv
design/ascm_cfg_if.sv
design/ascm_cfg_regs.sv
design/ascm_in_reg.sv
design/ascm_core.sv
design/audio_safety_ceiling_mute_top.sv
test/audio_safety_ceiling_mute_top_test.sv
